// ----- hw/rtl/bdpl_pkg.sv -----
`default_nettype none

package bdpl_pkg;

	// Neurons served by one weight or accumulator word.
	localparam int LANES = 8;
	localparam int COUNT_W = 10;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;
	// Active neurons never exceed this, so at most eight accumulator rows exist.
	localparam int OUT_CAP = 64;
	localparam int ROW_W = 3;

	localparam logic OP_WEIGHT = 1'b0;
	localparam logic OP_ACT = 1'b1;

	localparam logic REG_INPUT_BITS = 1'b0;
	localparam logic REG_OUTPUT_COUNT = 1'b1;

	localparam logic [9:0] INPUT_BITS_RST = 10'd512;
	localparam logic [6:0] OUTPUT_COUNT_RST = 7'd64;

	typedef logic [LANES-1:0][COUNT_W-1:0] lane_counts_t;
	typedef logic [LANES-1:0][7:0] lane_bytes_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_EMIT
	} state_t;

	// Accumulator memory command for one cycle.
	typedef struct packed {
		logic rd_en;
		logic [ROW_W-1:0] rd_row;
		logic wr_en;
		logic [ROW_W-1:0] wr_row;
		logic clear;
	} acc_cmd_t;

	function automatic logic [3:0] ones8(input logic [7:0] v);
		logic [3:0] c;
		c = 4'd0;
		for (int i = 0; i < 8; i++) begin
			c = c + {3'd0, v[i]};
		end
		return c;
	endfunction

	function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
			input logic [3:0] b);
		logic [COUNT_W:0] s;
		s = {1'b0, a} + {{(COUNT_W-3){1'b0}}, b};
		return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/binary_dense_popcount_layer.sv -----
`default_nettype none

// Channel   | Handshake              | Payload
// ----------+------------------------+---------------------------------------------
// input     | in_valid / in_ready    | operation, neuron_index, byte_index,
//           |                        | data_byte, last_byte
// output    | out_valid / out_ready  | out_byte, out_index, out_last
// config    | cfg_valid / cfg_ready  | cfg_index (0 input bits, 1 output count),
//           |                        | cfg_data
//
// An activation byte takes one read-modify-write of the weight and counter
// memories per group of eight active neurons. After a last byte each output
// byte takes a counter row read, then the threshold into the output register,
// and waits while the output stalls. Reset clears the counters through per-row
// valid bits, with no sweep; the weight memory is not cleared. A waiting output
// transaction does not block the next input item.
module binary_dense_popcount_layer #(
	parameter int MAX_INPUT_BYTES = 64,
	parameter int MAX_OUTPUTS = 64
) (
	input wire logic clk,
	input wire logic arst_n,

	input wire logic in_valid,
	output logic in_ready,
	input wire logic operation,
	input wire logic [5:0] neuron_index,
	input wire logic [5:0] byte_index,
	input wire logic [7:0] data_byte,
	input wire logic last_byte,

	output logic out_valid,
	input wire logic out_ready,
	output logic [7:0] out_byte,
	output logic [2:0] out_index,
	output logic out_last,

	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [9:0] cfg_data
);

	localparam int WGROUPS = (MAX_OUTPUTS + 7) / 8;
	localparam int WDEPTH = WGROUPS * MAX_INPUT_BYTES;
	localparam int WAW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int ACT_CAP = (MAX_OUTPUTS < bdpl_pkg::OUT_CAP) ? MAX_OUTPUTS
		: bdpl_pkg::OUT_CAP;
	localparam int AROWS = (WGROUPS < 8) ? WGROUPS : 8;
	localparam int ARW = (AROWS > 1) ? $clog2(AROWS) : 1;

	// Configuration registers; the user must write them only while idle, the block does not enforce it.
	logic [9:0] input_bits_q;
	logic [6:0] output_count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_bits_q <= bdpl_pkg::INPUT_BITS_RST;
			output_count_q <= bdpl_pkg::OUTPUT_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bdpl_pkg::REG_INPUT_BITS: input_bits_q <= cfg_data;
				bdpl_pkg::REG_OUTPUT_COUNT: output_count_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Active neurons and the number of eight-neuron groups they span.
	logic [6:0] act;
	logic [7:0] act_round;
	logic [3:0] ngroups;

	assign act = (output_count_q > 7'(ACT_CAP)) ? 7'(ACT_CAP) : output_count_q;
	assign act_round = {1'b0, act} + 8'd7;
	assign ngroups = act_round[6:3];

	// Sequencer state and the item held while it is processed.
	bdpl_pkg::state_t state_q, state_d;
	logic [2:0] g_q;
	logic [3:0] k_q;
	logic [5:0] byte_q;
	logic [7:0] data_q;
	logic last_q;

	// Stage 1: a counter row read last cycle lands now.
	logic wb_s1;
	logic [2:0] wb_row_s1;
	logic em_s1;
	logic [2:0] em_row_s1;

	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic [2:0] out_index_q;
	logic out_last_q;

	logic accept;
	logic byte_ok;
	logic neuron_ok;
	logic run_rd;
	logic emit_rd;
	logic emit_done;
	logic em_last;

	bdpl_pkg::acc_cmd_t acc_cmd;
	bdpl_pkg::lane_counts_t acc_rd;
	bdpl_pkg::lane_counts_t acc_wr;
	bdpl_pkg::lane_bytes_t w_rd;

	logic w_wr_en;
	logic [WAW-1:0] w_wr_addr;
	logic [WAW-1:0] w_rd_addr;

	assign accept = in_valid && in_ready;
	assign byte_ok = int'(byte_index) < MAX_INPUT_BYTES;
	assign neuron_ok = int'(neuron_index) < MAX_OUTPUTS;
	assign em_last = ({1'b0, em_row_s1} + 4'd1) == ngroups;

	// Weight writes go straight to the store when accepted.
	assign w_wr_en = accept && (operation == bdpl_pkg::OP_WEIGHT) && byte_ok && neuron_ok;
	assign w_wr_addr = WAW'(int'(neuron_index[5:3]) * MAX_INPUT_BYTES + int'(byte_index));
	assign w_rd_addr = WAW'(int'(g_q) * MAX_INPUT_BYTES + int'(byte_q));

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		run_rd = 1'b0;
		emit_rd = 1'b0;
		emit_done = 1'b0;
		unique case (state_q)
			bdpl_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && operation == bdpl_pkg::OP_ACT) begin
					if (byte_ok && ngroups != 4'd0) begin
						state_d = bdpl_pkg::ST_RUN;
					end else if (last_byte) begin
						state_d = bdpl_pkg::ST_EMIT;
					end
				end
			end
			bdpl_pkg::ST_RUN: begin
				// One group read per cycle; the write-back of each row is registered behind its read.
				run_rd = 1'b1;
				if ({1'b0, g_q} + 4'd1 == ngroups) begin
					state_d = last_q ? bdpl_pkg::ST_EMIT : bdpl_pkg::ST_IDLE;
				end
			end
			bdpl_pkg::ST_EMIT: begin
				if (ngroups == 4'd0) begin
					emit_done = 1'b1;
					state_d = bdpl_pkg::ST_IDLE;
				end else if (em_s1 && em_last) begin
					emit_done = 1'b1;
					state_d = bdpl_pkg::ST_IDLE;
				end else begin
					// Hold the read while a write-back or an earlier row read is in flight or
					// the output slot cannot take the row next cycle.
					emit_rd = !wb_s1 && !em_s1 && (!out_valid_q || out_ready)
						&& (k_q < ngroups);
				end
			end
			default: state_d = bdpl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		acc_cmd.rd_en = run_rd || emit_rd;
		acc_cmd.rd_row = run_rd ? g_q : k_q[2:0];
		acc_cmd.wr_en = wb_s1;
		acc_cmd.wr_row = wb_row_s1;
		acc_cmd.clear = emit_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdpl_pkg::ST_IDLE;
			wb_s1 <= 1'b0;
			em_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wb_s1 <= run_rd;
			em_s1 <= emit_rd;
			if (em_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= byte_index;
			data_q <= data_byte;
			last_q <= last_byte;
			g_q <= 3'd0;
			k_q <= 4'd0;
		end else begin
			if (run_rd) begin
				g_q <= g_q + 3'd1;
			end
			if (emit_rd) begin
				k_q <= k_q + 4'd1;
			end
		end
		wb_row_s1 <= g_q;
		em_row_s1 <= k_q[2:0];
		if (em_s1) begin
			out_index_q <= em_row_s1;
			out_last_q <= em_last;
			for (int j = 0; j < bdpl_pkg::LANES; j++) begin
				// Neuron 8k+j goes to bit 7-j; padding neurons give 0.
				out_byte_q[7 - j] <= (({em_row_s1, 3'(j)} < act)
					&& ({acc_rd[j], 1'b0} > {1'b0, input_bits_q}));
			end
		end
	end

	// Add popcount(activation ^ weight) lane by lane, saturating.
	always_comb begin
		for (int j = 0; j < bdpl_pkg::LANES; j++) begin
			acc_wr[j] = bdpl_pkg::sat_add(acc_rd[j], bdpl_pkg::ones8(data_q ^ w_rd[j]));
		end
	end

	bdpl_wmem #(
		.DEPTH(WDEPTH),
		.AW(WAW)
	) u_wmem (
		.clk(clk),
		.wr_en(w_wr_en),
		.wr_addr(w_wr_addr),
		.wr_lane(neuron_index[2:0]),
		.wr_byte(data_byte),
		.rd_en(run_rd),
		.rd_addr(w_rd_addr),
		.rd_data(w_rd)
	);

	bdpl_amem #(
		.ROWS(AROWS),
		.RW(ARW)
	) u_amem (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(acc_cmd),
		.wr_data(acc_wr),
		.rd_data(acc_rd)
	);

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_index = out_index_q;
	assign out_last = out_last_q;

	// A counter row is never read in the cycle it is written back.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_cmd.rd_en && acc_cmd.wr_en) |-> (acc_cmd.rd_row != acc_cmd.wr_row))
		else $error("counter row read during its write-back");

	// Clearing never coincides with a write-back.
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc_cmd.clear |-> !wb_s1)
		else $error("counters cleared with a write-back in flight");

	// A landing row always finds the output register free.
	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		em_s1 |-> !out_valid_q)
		else $error("output row lands on a full output register");

	// The emit pointer never runs past the active groups.
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bdpl_pkg::ST_EMIT) |-> (k_q <= ngroups))
		else $error("emit pointer beyond active groups");

	// Inputs are refused while counters are updated or emitted.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(run_rd || em_s1) |-> !in_ready)
		else $error("input accepted while busy");

endmodule

`default_nettype wire

// ----- hw/rtl/bdpl_wmem.sv -----
`default_nettype none

// Weight store: one word per (neuron group, input byte), eight byte lanes wide.
module bdpl_wmem #(
	parameter int DEPTH = 512,
	parameter int AW = 9
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [AW-1:0] wr_addr,
	input wire logic [2:0] wr_lane,
	input wire logic [7:0] wr_byte,
	input wire logic rd_en,
	input wire logic [AW-1:0] rd_addr,
	output bdpl_pkg::lane_bytes_t rd_data
);

	bdpl_pkg::lane_bytes_t mem [DEPTH];
	bdpl_pkg::lane_bytes_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr][wr_lane] <= wr_byte;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bdpl_amem.sv -----
`default_nettype none

// Mismatch counters, eight neurons per row. A row that is not valid reads as zero.
module bdpl_amem #(
	parameter int ROWS = 8,
	parameter int RW = 3
) (
	input wire logic clk,
	input wire logic arst_n,
	input bdpl_pkg::acc_cmd_t cmd,
	input bdpl_pkg::lane_counts_t wr_data,
	output bdpl_pkg::lane_counts_t rd_data
);

	bdpl_pkg::lane_counts_t mem [ROWS];
	bdpl_pkg::lane_counts_t rd_data_q;
	logic [ROWS-1:0] valid_q;
	logic rd_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_row[RW-1:0]] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[cmd.rd_row[RW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				valid_q <= '0;
			end else if (cmd.wr_en) begin
				valid_q[cmd.wr_row[RW-1:0]] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_valid_q <= valid_q[cmd.rd_row[RW-1:0]];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ----- verif/binary_dense_popcount_layer_tb.sv -----
`default_nettype none

module binary_dense_popcount_layer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bdpl_pkg::*;

	localparam int NEURONS = 64;
	localparam int ROW_BYTES = 64;
	// Cycles to let pass once the last expected byte is in: long enough for an
	// activation byte to finish, so this covers items that produce nothing.
	localparam int QUIET_CYCLES = 40;
	// Cycles without any transaction before the run is declared hung.
	localparam int HANG_LIMIT = 2000;
	localparam int SAT_LENGTH = 140;

	// One item on the input channel, plus a flag that makes the feeder hold it
	// back until every packed byte already owed has come out.
	typedef struct packed {
		logic op;
		logic [5:0] neuron;
		logic [5:0] col;
		logic [7:0] data;
		logic last;
		logic hold_for_drain;
	} feed_item_t;

	typedef struct packed {
		logic [7:0] bits;
		logic [2:0] index;
		logic last;
	} out_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = OP_WEIGHT;
	logic [5:0] neuron_index = 6'd0;
	logic [5:0] byte_index = 6'd0;
	logic [7:0] data_byte = 8'd0;
	logic last_byte = 1'b0;

	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] out_byte;
	logic [2:0] out_index;
	logic out_last;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = REG_INPUT_BITS;
	logic [9:0] cfg_data = 10'd0;

	// Shadow of the layer: weight rows, per-neuron mismatch counters, registers.
	logic [7:0] weight_rows [NEURONS][ROW_BYTES];
	logic [9:0] miss_count [NEURONS];
	logic [9:0] thresh_bits = INPUT_BITS_RST;
	logic [6:0] active_cfg = OUTPUT_COUNT_RST;

	feed_item_t feed_q[$];
	out_word_t due_bytes[$];

	logic in_taken = 1'b0;
	logic out_taken = 1'b0;
	int send_gap = 0;
	int recv_wait = 0;
	bit send_calm = 1'b1;
	bit recv_calm = 1'b0;

	int fail_count = 0;
	int hang_count = 0;
	int n_queued = 0;
	int n_writes = 0;
	int n_acts = 0;
	int n_results = 0;
	int n_settings = 0;

	binary_dense_popcount_layer uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.neuron_index(neuron_index),
		.byte_index(byte_index),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.out_index(out_index),
		.out_last(out_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 0;
	end

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t: MISMATCH %s", $realtime, msg);
		end
	endtask

	// Advance the shadow layer by one accepted item and queue the packed bytes
	// that it owes. Weight writes only update the row store.
	task automatic dense_step(input feed_item_t it);
		int act;
		int total;
		int nbytes;
		int i;
		int j;
		int k;
		int n;
		logic [7:0] bits;
		out_word_t w;
		act = (int'(active_cfg) > OUT_CAP) ? OUT_CAP : int'(active_cfg);
		if (it.op == OP_WEIGHT) begin
			weight_rows[it.neuron][it.col] = it.data;
		end else begin
			for (i = 0; i < act; i++) begin
				total = int'(miss_count[i]) + $countones(it.data ^ weight_rows[i][it.col]);
				miss_count[i] = (total > int'(COUNT_MAX)) ? COUNT_MAX : 10'(total);
			end
			if (it.last) begin
				nbytes = (act + 7) / 8;
				for (k = 0; k < nbytes; k++) begin
					bits = 8'd0;
					for (j = 0; j < 8; j++) begin
						n = k * 8 + j;
						// Centered threshold, signed; neurons past the active
						// count leave their bit as zero padding.
						if (n < act && 2 * int'(miss_count[n]) - int'(thresh_bits) > 0) begin
							bits[7 - j] = 1'b1;
						end
					end
					w.bits = bits;
					w.index = 3'(k);
					w.last = (k + 1 == nbytes);
					due_bytes.push_back(w);
				end
				for (i = 0; i < NEURONS; i++) begin
					miss_count[i] = 10'd0;
				end
			end
		end
	endtask

	// Sample both channels at the rising edge: predict on each accepted item,
	// check each accepted packed byte against the oldest one owed.
	always @(posedge clk) begin : monitor
		out_word_t exp;
		feed_item_t seen;
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			out_taken <= out_valid && out_ready;
			if (in_valid && in_ready) begin
				seen.op = operation;
				seen.neuron = neuron_index;
				seen.col = byte_index;
				seen.data = data_byte;
				seen.last = last_byte;
				seen.hold_for_drain = 1'b0;
				dense_step(seen);
				if (operation == OP_WEIGHT) begin
					n_writes++;
				end else begin
					n_acts++;
				end
			end
			if (out_valid && out_ready) begin
				n_results++;
				if (due_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %h index %0d last %0d",
						out_byte, out_index, out_last));
				end else begin
					exp = due_bytes.pop_front();
					if (out_byte !== exp.bits || out_index !== exp.index ||
							out_last !== exp.last) begin
						report_mismatch($sformatf(
							"byte exp %h got %h, index exp %0d got %0d, last exp %0d got %0d",
							exp.bits, out_byte, exp.index, out_index, exp.last, out_last));
					end
				end
			end
			// Watchdog: any transaction on any channel resets it.
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready)) begin
				hang_count <= 0;
			end else if (hang_count + 1 >= HANG_LIMIT) begin
				$display("timeout: %0d cycles without a transaction", HANG_LIMIT);
				$display("binary_dense_popcount_layer_tb NOT OK");
				$finish;
			end else begin
				hang_count <= hang_count + 1;
			end
		end
	end

	// Feeder: hold the current item until it is accepted, then wait out the gap
	// drawn for it before presenting the next one.
	always @(negedge clk) begin : feeder
		feed_item_t it;
		if (arst_n && (!in_valid || in_taken)) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (feed_q.size() != 0 &&
					!(feed_q[0].hold_for_drain && due_bytes.size() != 0)) begin
				it = feed_q.pop_front();
				operation <= it.op;
				neuron_index <= it.neuron;
				byte_index <= it.col;
				data_byte <= it.data;
				last_byte <= it.last;
				in_valid <= 1'b1;
				send_gap <= send_calm ? 0 : $urandom_range(0, 15);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result side: after each accepted byte drop ready for a drawn number of cycles.
	always @(negedge clk) begin : sink
		int hold;
		if (arst_n) begin
			hold = out_taken ? (recv_calm ? 0 : int'($urandom_range(0, 15))) : recv_wait;
			if (hold > 0) begin
				out_ready <= 1'b0;
				recv_wait <= hold - 1;
			end else begin
				out_ready <= 1'b1;
				recv_wait <= 0;
			end
		end
	end

	function automatic logic [5:0] live_col();
		// Only these columns are loaded for every neuron, so activations never
		// touch an unwritten weight. Together they toggle every index bit.
		case ($urandom_range(0, 4))
			0: return 6'd0;
			1: return 6'd5;
			2: return 6'd21;
			3: return 6'd42;
			default: return 6'd63;
		endcase
	endfunction

	function automatic logic [7:0] act_data();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_item(input logic op, input logic [5:0] neuron, input logic [5:0] col,
			input logic [7:0] data, input logic last, input logic hold);
		feed_item_t it;
		it.op = op;
		it.neuron = neuron;
		it.col = col;
		it.data = data;
		it.last = last;
		it.hold_for_drain = hold;
		feed_q.push_back(it);
		n_queued++;
	endtask

	// One well-formed activation vector, now and then broken up by a weight
	// write to an arbitrary location.
	task automatic push_vector(input int len, input logic hold);
		int b;
		for (b = 0; b < len; b++) begin
			if (b != 0 && $urandom_range(0, 9) == 0) begin
				push_item(OP_WEIGHT, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
			end
			push_item(OP_ACT, 6'($urandom_range(0, 63)), live_col(), act_data(),
				b == len - 1, hold && b == 0);
		end
	endtask

	// Wait until the feeder is empty and nothing is owed, then let the block
	// finish any item that produces no bytes.
	task automatic settle();
		do @(posedge clk);
		while (feed_q.size() != 0 || in_valid || due_bytes.size() != 0);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [9:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		if (idx == REG_INPUT_BITS) begin
			thresh_bits = val;
		end else begin
			active_cfg = val[6:0];
		end
		n_settings++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int ph;
		int n;
		int c;
		int phase_end;
		logic [9:0] ibc;
		logic [6:0] oc;
		for (n = 0; n < NEURONS; n++) begin
			miss_count[n] = 10'd0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Load the live columns of every weight row; last_byte is junk here.
		for (n = 0; n < NEURONS; n++) begin
			for (c = 0; c < 5; c++) begin
				push_item(OP_WEIGHT, 6'(n), (c == 0) ? 6'd0 : (c == 1) ? 6'd5 :
					(c == 2) ? 6'd21 : (c == 3) ? 6'd42 : 6'd63,
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
			end
		end
		settle();
		send_calm = 1'b0;

		// Directed: reset registers, extreme columns and data.
		push_item(OP_ACT, 6'd0, 6'd0, 8'h00, 1'b0, 1'b0);
		push_item(OP_ACT, 6'd63, 6'd63, 8'hFF, 1'b1, 1'b0);
		push_item(OP_WEIGHT, 6'd3, 6'd42, 8'h0F, 1'b1, 1'b0);
		push_item(OP_ACT, 6'd0, 6'd42, 8'hF0, 1'b1, 1'b0);
		settle();
		// Single neuron, low threshold: seven padding bits.
		write_reg(REG_INPUT_BITS, 10'd1);
		write_reg(REG_OUTPUT_COUNT, 10'd1);
		push_item(OP_ACT, 6'd0, 6'd21, 8'hA5, 1'b1, 1'b0);
		push_item(OP_ACT, 6'd0, 6'd5, 8'h5A, 1'b0, 1'b0);
		push_item(OP_ACT, 6'd0, 6'd0, 8'h3C, 1'b1, 1'b0);
		settle();
		// Count above the cap, highest threshold.
		write_reg(REG_INPUT_BITS, 10'd1023);
		write_reg(REG_OUTPUT_COUNT, 10'd127);
		push_item(OP_ACT, 6'd0, 6'd63, 8'hFF, 1'b1, 1'b0);
		settle();
		// Zero threshold: a zero count must still give a zero bit; nine
		// neurons spill one bit into a second byte.
		write_reg(REG_INPUT_BITS, 10'd0);
		write_reg(REG_OUTPUT_COUNT, 10'd9);
		push_item(OP_ACT, 6'd0, 6'd42, 8'h00, 1'b1, 1'b0);
		settle();
		// Accumulate, end the vector with no active neurons, and check that the
		// counters were cleared anyway.
		write_reg(REG_INPUT_BITS, 10'd8);
		write_reg(REG_OUTPUT_COUNT, 10'd64);
		push_item(OP_ACT, 6'd0, 6'd0, 8'hFF, 1'b0, 1'b0);
		settle();
		write_reg(REG_OUTPUT_COUNT, 10'd0);
		push_item(OP_ACT, 6'd0, 6'd21, 8'h00, 1'b1, 1'b0);
		settle();
		write_reg(REG_OUTPUT_COUNT, 10'd64);
		push_item(OP_ACT, 6'd0, 6'd63, 8'h81, 1'b1, 1'b0);
		settle();
		write_reg(REG_OUTPUT_COUNT, 10'd100);
		push_item(OP_ACT, 6'd0, 6'd5, 8'h69, 1'b1, 1'b0);
		settle();

		// Random phases, one register setting each. Thresholds mostly sit near
		// the typical counts so the output bits mix.
		for (ph = 0; ph < 6; ph++) begin
			settle();
			case ($urandom_range(0, 5))
				0: ibc = 10'd1;
				1: ibc = 10'd512;
				2: ibc = 10'd1023;
				default: ibc = 10'($urandom_range(2, 64));
			endcase
			case ($urandom_range(0, 5))
				0: oc = 7'd64;
				1: oc = 7'd1;
				2: oc = 7'($urandom_range(65, 127));
				default: oc = 7'($urandom_range(1, 64));
			endcase
			write_reg(REG_INPUT_BITS, ibc);
			write_reg(REG_OUTPUT_COUNT, {3'd0, oc});
			send_calm = (ph % 3 == 2);
			recv_calm = (ph % 3 == 1);
			phase_end = n_queued + 35;
			while (n_queued < phase_end) begin
				if ($urandom_range(0, 4) == 0) begin
					push_item(OP_WEIGHT, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
				end else begin
					// In phase three every vector waits for the previous output.
					push_vector($urandom_range(1, 6), ph == 3);
				end
			end
		end
		settle();
		send_calm = 1'b0;
		recv_calm = 1'b0;

		// Saturation: zero one live column everywhere and hit it with all-ones
		// long enough to push every counter past its ceiling.
		write_reg(REG_INPUT_BITS, 10'd1023);
		write_reg(REG_OUTPUT_COUNT, 10'd64);
		for (n = 0; n < NEURONS; n++) begin
			push_item(OP_WEIGHT, 6'(n), 6'd5, 8'h00, 1'b0, 1'b0);
		end
		for (n = 0; n < SAT_LENGTH; n++) begin
			push_item(OP_ACT, 6'd0, 6'd5, 8'hFF, n == SAT_LENGTH - 1, 1'b0);
		end
		settle();

		if (due_bytes.size() != 0) begin
			report_mismatch($sformatf("%0d packed bytes never came out", due_bytes.size()));
		end
		$display("checked %0d output bytes from %0d activation bytes and %0d weight writes,",
			n_results, n_acts, n_writes);
		$display("over %0d register writes; %0d mismatches", n_settings, fail_count);
		if (fail_count == 0) begin
			$display("binary_dense_popcount_layer_tb OK");
		end else begin
			$display("binary_dense_popcount_layer_tb NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/bdpl_pkg.sv
hw/rtl/bdpl_wmem.sv
hw/rtl/bdpl_amem.sv
hw/rtl/binary_dense_popcount_layer.sv
verif/binary_dense_popcount_layer_tb.sv
